// ===== src/bjd_pkg.sv =====
// shared constants, payload types and helpers for the bitset jaccard/dot distance unit
package bjd_pkg;

   localparam int MAX_FEATURE_BITS = 65536;
   localparam int CNT_W            = $clog2(MAX_FEATURE_BITS + 1);
   localparam int WORD_W           = 64;
   localparam int LANES            = 8;
   localparam int LANE_W           = WORD_W / LANES;
   localparam int LANE_CNT_W       = $clog2(LANE_W + 1);
   localparam int SUM_W            = $clog2(WORD_W + 1);
   localparam int FRAC_W           = 16;
   localparam int Q_W              = FRAC_W + 1;
   localparam int ITER_W           = $clog2(FRAC_W);
   localparam int DIST_W           = 18;
   localparam int MAG_W            = (CNT_W > DIST_W) ? CNT_W : DIST_W;
   localparam int Q16_ONE          = 1 << FRAC_W;
   localparam int DOT_LIMIT        = 1 << (DIST_W - 1);

   localparam logic MODE_JACCARD = 1'b0;
   localparam logic MODE_DOT     = 1'b1;

   typedef struct packed {
      logic [WORD_W-1:0] word_a;
      logic [WORD_W-1:0] word_b;
      logic              last_word;
   } req_type;

   typedef struct packed {
      logic signed [DIST_W-1:0] distance;
      logic                     empty_union;
   } rsp_type;

   typedef struct packed {
      logic [LANE_CNT_W-1:0] and_cnt;
      logic [LANE_CNT_W-1:0] or_cnt;
   } lane_cnt_type;

   typedef struct packed {
      logic             start;
      logic             mode;
      logic [CNT_W-1:0] inter;
      logic [CNT_W-1:0] uni;
   } div_start_type;

   // count plus word popcount, clamped at the feature limit
   function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] acc,
                                                input logic [SUM_W-1:0] n);
      logic [CNT_W:0] s;
      s = {1'b0, acc} + (CNT_W+1)'(n);
      if (s > (CNT_W+1)'(MAX_FEATURE_BITS)) begin
         s = (CNT_W+1)'(MAX_FEATURE_BITS);
      end
      return s[CNT_W-1:0];
   endfunction

endpackage

// ===== src/bjd_lane.sv =====
// one popcount lane: ones of the and and of the or of a slice of both words
module bjd_lane
   import bjd_pkg::*;
(
   input  logic [LANE_W-1:0] slice_a,
   input  logic [LANE_W-1:0] slice_b,
   output lane_cnt_type      cnt
);

   always_comb begin
      cnt = '0;
      for (int i = 0; i < LANE_W; i++) begin
         cnt.and_cnt = cnt.and_cnt + LANE_CNT_W'(slice_a[i] & slice_b[i]);
         cnt.or_cnt  = cnt.or_cnt  + LANE_CNT_W'(slice_a[i] | slice_b[i]);
      end
   end

endmodule

// ===== src/bjd_accum.sv =====
// merges the lane counts and keeps the saturating intersection and union counts
module bjd_accum
   import bjd_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     stage_valid,
   input  logic                     stage_last,
   input  lane_cnt_type [LANES-1:0] stage_cnt,
   input  logic                     mode,
   output div_start_type            div_start
);

   logic [CNT_W-1:0] inter_ff, inter_in;
   logic [CNT_W-1:0] uni_ff, uni_in;
   logic [SUM_W-1:0] and_sum, or_sum;
   logic [CNT_W-1:0] inter_next, uni_next;

   always_comb begin
      and_sum = '0;
      or_sum  = '0;
      for (int i = 0; i < LANES; i++) begin
         and_sum = and_sum + SUM_W'(stage_cnt[i].and_cnt);
         or_sum  = or_sum  + SUM_W'(stage_cnt[i].or_cnt);
      end
      inter_next = sat_add(inter_ff, and_sum);
      uni_next   = sat_add(uni_ff, or_sum);
   end

   always_comb begin
      inter_in        = inter_ff;
      uni_in          = uni_ff;
      div_start.start = 1'b0;
      div_start.mode  = mode;
      div_start.inter = inter_next;
      div_start.uni   = uni_next;
      if (stage_valid) begin
         if (stage_last) begin
            // hand the totals to the divider and start the next vector pair at zero
            div_start.start = 1'b1;
            inter_in        = '0;
            uni_in          = '0;
         end else begin
            inter_in = inter_next;
            uni_in   = uni_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         inter_ff <= '0;
         uni_ff   <= '0;
      end else begin
         inter_ff <= inter_in;
         uni_ff   <= uni_in;
      end
   end

endmodule

// ===== src/bjd_divider.sv =====
// forms the distance: restoring division for the jaccard ratio, direct negate in dot mode
module bjd_divider
   import bjd_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  div_start_type div_start,
   input  logic          out_free,
   output logic          res_valid,
   output rsp_type       res_data
);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_CALC = 3'b010,
      ST_DONE = 3'b100
   } state_type;

   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  rem_ff, rem_in;
   logic [CNT_W-1:0]  uni_ff, uni_in;
   logic [Q_W-1:0]    q_ff, q_in;
   logic [ITER_W-1:0] iter_ff, iter_in;
   rsp_type           res_ff, res_in;

   logic [CNT_W:0]    shifted;
   logic              q_bit;
   logic [Q_W-1:0]    q_next;
   logic [MAG_W-1:0]  mag;

   always_comb begin
      shifted = {rem_ff, 1'b0};
      q_bit   = (shifted >= {1'b0, uni_ff});
      q_next  = {q_ff[Q_W-2:0], q_bit};
      mag     = MAG_W'(div_start.inter);
      if (mag > MAG_W'(DOT_LIMIT)) begin
         mag = MAG_W'(DOT_LIMIT);
      end
   end

   always_comb begin
      state_in = state_ff;
      rem_in   = rem_ff;
      uni_in   = uni_ff;
      q_in     = q_ff;
      iter_in  = iter_ff;
      res_in   = res_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (div_start.start) begin
               res_in.empty_union = 1'b0;
               res_in.distance    = '0;
               state_in           = ST_DONE;
               if (div_start.mode == MODE_DOT) begin
                  res_in.distance = DIST_W'(MAG_W'(0) - mag);
               end else if (div_start.uni == '0) begin
                  res_in.empty_union = 1'b1;
               end else if (div_start.inter != div_start.uni) begin
                  // intersection below union: remainder stays below the divisor
                  rem_in   = div_start.inter;
                  uni_in   = div_start.uni;
                  q_in     = '0;
                  iter_in  = '0;
                  state_in = ST_CALC;
               end
            end
         end
         ST_CALC: begin
            q_in = q_next;
            if (q_bit) begin
               rem_in = CNT_W'(shifted - {1'b0, uni_ff});
            end else begin
               rem_in = shifted[CNT_W-1:0];
            end
            iter_in = iter_ff + ITER_W'(1);
            if (iter_ff == ITER_W'(FRAC_W - 1)) begin
               res_in.distance    = DIST_W'(Q16_ONE) - DIST_W'(q_next);
               res_in.empty_union = 1'b0;
               state_in           = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      uni_ff  <= uni_in;
      q_ff    <= q_in;
      iter_ff <= iter_in;
      res_ff  <= res_in;
   end

   assign res_valid = (state_ff == ST_DONE);
   assign res_data  = res_ff;

endmodule

// ===== src/bitset_jaccard_dot_distance_unit.sv =====
// top level: eight popcount lanes, count merge and accumulation, distance divider, output register
// words are taken one per cycle while req_ready is high, the lane counts registered for one stage
// after a last word req_ready stays low while the distance forms (directly in dot mode, for an
// empty union or equal counts, else by the 16-step restoring divider) and while rsp is stalled;
// rsp_valid rises with req_ready and the next vector pair may stream while the result waits
// synchronous reset clears counts, the mode (to jaccard) and all valid flags
module bitset_jaccard_dot_distance_unit
   import bjd_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data,
   input  logic    csr_valid,
   output logic    csr_ready,
   input  logic    csr_data
);

   logic                     mode_ff, mode_in;
   logic                     hold_ff, hold_in;
   logic                     stage_valid_ff, stage_valid_in;
   logic                     stage_last_ff;
   lane_cnt_type [LANES-1:0] stage_cnt_ff;
   lane_cnt_type [LANES-1:0] lane_cnt;
   logic                     rsp_valid_ff, rsp_valid_in;
   rsp_type                  rsp_data_ff;
   logic                     req_fire;
   logic                     out_free;
   logic                     handoff;
   logic                     div_valid;
   rsp_type                  div_data;
   div_start_type            div_start;

   assign csr_ready = 1'b1;
   assign req_ready = ~hold_ff;
   assign req_fire  = req_valid & req_ready;
   assign out_free  = ~rsp_valid_ff | rsp_ready;
   assign handoff   = div_valid & out_free;

   for (genvar i = 0; i < LANES; i++) begin : g_lane
      bjd_lane u_lane (
         .slice_a (req_data.word_a[i*LANE_W +: LANE_W]),
         .slice_b (req_data.word_b[i*LANE_W +: LANE_W]),
         .cnt     (lane_cnt[i])
      );
   end

   bjd_accum u_accum (
      .clock       (clock),
      .reset       (reset),
      .stage_valid (stage_valid_ff),
      .stage_last  (stage_last_ff),
      .stage_cnt   (stage_cnt_ff),
      .mode        (mode_ff),
      .div_start   (div_start)
   );

   bjd_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .div_start (div_start),
      .out_free  (out_free),
      .res_valid (div_valid),
      .res_data  (div_data)
   );

   always_comb begin
      mode_in        = csr_valid ? csr_data : mode_ff;
      stage_valid_in = req_fire;
      // no new words once a last word is in, until its result moves to the output
      priority if (req_fire && req_data.last_word) begin
         hold_in = 1'b1;
      end else if (handoff) begin
         hold_in = 1'b0;
      end else begin
         hold_in = hold_ff;
      end
      if (handoff) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff        <= MODE_JACCARD;
         hold_ff        <= 1'b0;
         stage_valid_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         mode_ff        <= mode_in;
         hold_ff        <= hold_in;
         stage_valid_ff <= stage_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         stage_cnt_ff  <= lane_cnt;
         stage_last_ff <= req_data.last_word;
      end
      if (handoff) begin
         rsp_data_ff <= div_data;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== src/bjd_checker.sv =====
// port-level checker for the distance unit, bound to the top level
module bjd_checker
   import bjd_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_ready,
   input req_type req_data,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);

   // a waiting result holds until taken
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("rsp item dropped or changed while stalled");

   // an empty union always reports zero distance
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.empty_union |-> rsp_data.distance == '0)
      else $error("empty union with nonzero distance");

   // input stalls right after the last word of a vector pair
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_data.last_word |=> !req_ready)
      else $error("item taken while a distance is still being formed");

   // no result right out of reset
   assert property (@(posedge clock)
      $past(reset) && !reset |-> !rsp_valid)
      else $error("rsp valid after reset");

endmodule

bind bitset_jaccard_dot_distance_unit bjd_checker u_bjd_checker (.*);
